// ----- hw/rtl/rgsc_pkg.sv -----
// rgsc_pkg: shared constants, types and state codes for the region grid shape checker
// used by rgsc_div, rgsc_check and region_grid_shape_checker; no dependencies
`default_nettype none

package rgsc_pkg;

    // row store depth and derived widths
    localparam int unsigned MAX_ROWS = 256;
    localparam int unsigned AddrW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CntW     = $clog2(MAX_ROWS + 1);

    // interval index, row width and column widths
    localparam int unsigned DataW    = 32;
    localparam int unsigned WidthW   = 21;
    localparam int unsigned ColW     = 20;
    localparam int unsigned DivCntW  = $clog2(DataW);

    localparam logic [WidthW-1:0] WIDTH_MAX = 21'h100000;
    localparam logic [WidthW-1:0] WIDTH_MIN = 21'h000001;

    // sequencer states of the checker
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_COMPARE,
        S_DONE
    } t_state;

    // one input item as handed to the checker
    typedef struct packed {
        logic [DataW-1:0] intv_begin;
        logic [DataW-1:0] intv_end;
        logic             first_in_job;
        logic             first_in_region;
        logic             last_in_region;
        logic             last_in_job;
    } t_item;

    // one result item
    typedef struct packed {
        logic shape_ok;
        logic done_res;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/rgsc_div.sv -----
// rgsc_div: radix-2 restoring divider, 32-bit dividend by row width, one bit per cycle
// depends on rgsc_pkg for widths
`default_nettype none

module rgsc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rgsc_pkg::DataW-1:0]    i_dividend,
    input  wire logic [rgsc_pkg::WidthW-1:0]   i_divisor,
    output logic                               o_done,
    output logic [rgsc_pkg::DataW-1:0]         o_quot,
    output logic [rgsc_pkg::ColW-1:0]          o_rem
);
    import rgsc_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DivCntW-1:0]  r_cnt;
    logic [WidthW-1:0]   r_rem;
    logic [DataW-1:0]    r_quo;
    logic [WidthW-1:0]   r_div;

    logic [WidthW-1:0]   w_trial;
    logic                w_fits;

    // trial subtraction of one step
    assign w_trial = {r_rem[WidthW-2:0], r_quo[DataW-1]};
    assign w_fits  = (w_trial >= r_div);

    // control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DivCntW'(1);
                if (r_cnt == DivCntW'(DataW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? (w_trial - r_div) : w_trial;
            r_quo <= {r_quo[DataW-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem[ColW-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/rgsc_check.sv -----
// rgsc_check: sequencer, row store and grid state of the shape checker
// depends on rgsc_pkg and rgsc_div
`default_nettype none

module rgsc_check (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire rgsc_pkg::t_item               i_item,
    input  wire logic [rgsc_pkg::WidthW-1:0]   i_width,
    input  wire logic                          i_out_free,
    output logic                               o_idle,
    output logic                               o_res_valid,
    output rgsc_pkg::t_result                  o_res
);
    import rgsc_pkg::*;

    // sequencer and grid state
    t_state            r_state,    n_state;
    logic [CntW-1:0]   r_count,    n_count;
    logic [CntW-1:0]   r_row_pos,  n_row_pos;
    logic              r_in_first, n_in_first;
    logic [ColW-1:0]   r_head_b,   n_head_b;
    logic [ColW-1:0]   r_head_l,   n_head_l;
    logic              r_failed,   n_failed;
    t_item             r_item;

    // row store
    logic [DataW-1:0]  r_rows [MAX_ROWS];
    logic [DataW-1:0]  r_ram_q;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [AddrW-1:0]  w_ram_addr;

    // dividers
    logic              w_div_start;
    logic              w_done_b, w_done_e;
    logic [DataW-1:0]  w_quot_b, w_quot_e;
    logic [ColW-1:0]   w_rem_b,  w_rem_e;

    logic              w_fail_in;
    logic              w_ordered;
    logic              w_span_diff;

    // sticky state as seen by the arriving item
    assign w_fail_in   = i_item.first_in_job ? 1'b0 : r_failed;
    assign w_ordered   = (i_item.intv_end > i_item.intv_begin);
    assign w_div_start = i_start && (r_state == S_IDLE) && !w_fail_in && w_ordered;
    assign w_span_diff = (w_rem_b != r_head_b) || (w_rem_e != r_head_l);

    // row and first column of the interval
    rgsc_div u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_item.intv_begin),
        .i_divisor  (i_width),
        .o_done     (w_done_b),
        .o_quot     (w_quot_b),
        .o_rem      (w_rem_b)
    );

    // row and last column of the interval
    rgsc_div u_div_e (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_item.intv_end - DataW'(1)),
        .i_divisor  (i_width),
        .o_done     (w_done_e),
        .o_quot     (w_quot_e),
        .o_rem      (w_rem_e)
    );

    // next state and grid update
    always_comb begin
        logic [CntW-1:0] v_pos;
        logic            v_first;
        logic            v_stop;

        n_state    = r_state;
        n_count    = r_count;
        n_row_pos  = r_row_pos;
        n_in_first = r_in_first;
        n_head_b   = r_head_b;
        n_head_l   = r_head_l;
        n_failed   = r_failed;
        w_ram_we   = 1'b0;
        w_ram_re   = 1'b0;
        w_ram_addr = r_row_pos[AddrW-1:0];
        v_pos      = r_row_pos;
        v_first    = r_in_first;
        v_stop     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_failed = w_fail_in;
                    if (i_item.first_in_job || i_item.first_in_region) begin
                        n_in_first = 1'b1;
                        n_row_pos  = '0;
                        n_count    = '0;
                    end
                    if (w_fail_in) begin
                        n_state = S_DONE;
                    end else if (!w_ordered) begin
                        n_failed = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_done_b) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                if (w_quot_b != w_quot_e) begin
                    n_failed = 1'b1;
                end else begin
                    // a new column span closes the current column
                    if ((r_row_pos != '0) && w_span_diff) begin
                        if (r_in_first) begin
                            v_first = 1'b0;
                            v_pos   = '0;
                        end else if (r_row_pos == r_count) begin
                            v_pos = '0;
                        end else begin
                            v_stop = 1'b1;
                        end
                    end
                    if (v_stop) begin
                        n_failed = 1'b1;
                    end else begin
                        n_in_first = v_first;
                        n_row_pos  = v_pos;
                        if (v_pos == '0) begin
                            n_head_b = w_rem_b;
                            n_head_l = w_rem_e;
                        end
                        if (v_first) begin
                            // first column records its rows
                            if (r_count >= CntW'(MAX_ROWS)) begin
                                n_failed = 1'b1;
                            end else begin
                                w_ram_we   = 1'b1;
                                w_ram_addr = r_count[AddrW-1:0];
                                n_count    = r_count + CntW'(1);
                                n_row_pos  = v_pos + CntW'(1);
                            end
                        end else if (v_pos >= r_count) begin
                            n_failed = 1'b1;
                        end else begin
                            // later column: fetch the recorded row
                            w_ram_re   = 1'b1;
                            w_ram_addr = v_pos[AddrW-1:0];
                            n_state    = S_COMPARE;
                        end
                    end
                end
            end
            S_COMPARE: begin
                n_state = S_DONE;
                if (r_ram_q != w_quot_b) begin
                    n_failed = 1'b1;
                end else begin
                    n_row_pos = r_row_pos + CntW'(1);
                    if (r_item.last_in_region && ((r_row_pos + CntW'(1)) != r_count)) begin
                        n_failed = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_row_pos  <= '0;
            r_in_first <= 1'b1;
            r_head_b   <= '0;
            r_head_l   <= '0;
            r_failed   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_row_pos  <= n_row_pos;
            r_in_first <= n_in_first;
            r_head_b   <= n_head_b;
            r_head_l   <= n_head_l;
            r_failed   <= n_failed;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == S_IDLE)) begin
            r_item <= i_item;
        end
    end

    // row store write port
    always_ff @(posedge i_clk) begin
        if (w_ram_we) begin
            r_rows[w_ram_addr] <= w_quot_b;
        end
    end

    // row store read port, registered output
    always_ff @(posedge i_clk) begin
        if (w_ram_re) begin
            r_ram_q <= r_rows[w_ram_addr];
        end
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_DONE);
    assign o_res.shape_ok = !r_failed;
    assign o_res.done_res = r_item.last_in_job;

    // checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("item started while checker busy");

    a_first_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_first |-> (r_row_pos == r_count))
        else $error("first column position lost track of row count");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_first |-> (r_row_pos <= r_count))
        else $error("later column ran past first column");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_ROWS))
        else $error("row count beyond row store");

    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_b == w_done_e)
        else $error("divider lanes out of step");

endmodule

`default_nettype wire

// ----- hw/rtl/region_grid_shape_checker.sv -----
// region_grid_shape_checker: top level with stream ports, row width register and result register
// depends on rgsc_pkg and rgsc_check
//
// Checks that a stream of flat index intervals, grouped into regions, tiles a regular grid
// over a matrix of row_width elements per row, and returns one item per input with a sticky
// pass flag (tdata bit 0) and the job end mark (tlast). Items are handled one at a time: an
// item runs through the two bit-serial dividers that form row and column of both interval
// ends, 32 steps each, then through the check, and for a later column through a compare
// against the row store; it skips the dividers when the job has already failed or the
// interval is empty. The next item is accepted as soon as the previous result sits in the
// output register. The row store (256 rows) needs no clearing after reset. The row width is
// to be written through the cfg channel only while no item is in flight, which the block does
// not enforce; 0 acts as 1 and values above 1048576 act as 1048576.
`default_nettype none

module region_grid_shape_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // interval_begin[31:0], interval_end[63:32]
    input  wire logic [2:0]  s_axis_tuser,  // first_in_job, first_in_region, last_in_region
    input  wire logic        s_axis_tlast,  // last_in_job
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // shape_ok[0], zero fill[7:1]
    output logic             m_axis_tlast,  // done_res
    // row width register
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [20:0] i_cfg_data
);
    import rgsc_pkg::*;

    logic [WidthW-1:0] r_width;
    logic              r_out_valid;
    t_result           r_out;

    t_item             w_item;
    t_result           w_res;
    logic              w_idle;
    logic              w_res_valid;
    logic              w_out_free;
    logic              w_in_acc;

    // row width register, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_MIN;
        end else if (i_cfg_valid) begin
            if (i_cfg_data == '0) begin
                r_width <= WIDTH_MIN;
            end else if (i_cfg_data > WIDTH_MAX) begin
                r_width <= WIDTH_MAX;
            end else begin
                r_width <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // input item unpacking
    assign w_item.intv_begin      = s_axis_tdata[31:0];
    assign w_item.intv_end        = s_axis_tdata[63:32];
    assign w_item.first_in_job    = s_axis_tuser[0];
    assign w_item.first_in_region = s_axis_tuser[1];
    assign w_item.last_in_region  = s_axis_tuser[2];
    assign w_item.last_in_job     = s_axis_tlast;

    assign s_axis_tready = w_idle;
    assign w_in_acc      = s_axis_tvalid && w_idle;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    rgsc_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_acc),
        .i_item      (w_item),
        .i_width     (r_width),
        .i_out_free  (w_out_free),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out.shape_ok};
    assign m_axis_tlast  = r_out.done_res;

endmodule

`default_nettype wire
